>>> design/rational_arithmetic_unit_assert.svh
// Assertion macros used by the datapath of the rational arithmetic unit
`ifndef RATIONAL_ARITHMETIC_UNIT_ASSERT_SVH
`define RATIONAL_ARITHMETIC_UNIT_ASSERT_SVH

// same-cycle implication, reset disables
`define RAU_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, reset disables
`define RAU_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> design/rau_pkg.sv
// Shared constants, codes and control types of the rational arithmetic unit
package rau_pkg;

	localparam int OW    = 16;
	localparam int MW    = 2 * OW;
	localparam int NUM_W = 33;
	localparam int DEN_W = 31;
	localparam int KW    = $clog2(MW + 1);
	localparam int CW    = $clog2(MW);

	localparam logic [1:0] OP_ADD = 2'd0;
	localparam logic [1:0] OP_SUB = 2'd1;
	localparam logic [1:0] OP_MUL = 2'd2;
	localparam logic [1:0] OP_DIV = 2'd3;

	localparam logic [2:0] MUL_NN   = 3'd0;
	localparam logic [2:0] MUL_DD   = 3'd1;
	localparam logic [2:0] MUL_ADQB = 3'd2;
	localparam logic [2:0] MUL_ANQB = 3'd3;
	localparam logic [2:0] MUL_ACC  = 3'd4;

	localparam logic GCD_DEN = 1'b0;
	localparam logic GCD_RES = 1'b1;

	localparam logic [1:0] DIV_AD = 2'd0;
	localparam logic [1:0] DIV_BD = 2'd1;
	localparam logic [1:0] DIV_RN = 2'd2;
	localparam logic [1:0] DIV_RD = 2'd3;

	typedef struct packed {
		logic       load;
		logic       gcd_load;
		logic       gcd_src;
		logic       gcd_step;
		logic       div_load;
		logic [1:0] div_src;
		logic       div_step;
		logic       mul_en;
		logic [2:0] mul_sel;
		logic       out_load;
	} cmd_t;

	typedef struct packed {
		logic undef;
		logic addsub;
		logic gcd_eq;
		logic div_last;
		logic rn_zero;
		logic out_free;
	} stat_t;

endpackage

>>> design/rational_arithmetic_unit.sv
// Top level of the rational arithmetic unit
// Takes two fractions and an operation (add, subtract, multiply, divide) and returns the
// result reduced by the gcd, sign in the numerator, zero as 0/1, and 0/0 with undefined set
// for a zero denominator or division by zero. One word is in work at a time; a finished
// result waits in the output register while the next word is accepted. Each word is first
// checked; add and subtract then run a one-step-per-cycle binary gcd of the denominators and
// two 32-step restoring divisions that give the scale factors, then the multiplies; multiply
// and divide go straight to the multiplies. A nonzero result is then reduced by a binary gcd
// and two more 32-step divisions; a zero result skips the reduction, and an undefined word
// goes straight to the output. The input stays stalled until the result is loaded; the next
// word is accepted in the idle state that follows.
module rational_arithmetic_unit (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [1:0]                       func,
	input  logic signed [rau_pkg::OW-1:0]    a_num,
	input  logic signed [rau_pkg::OW-1:0]    a_den,
	input  logic signed [rau_pkg::OW-1:0]    b_num,
	input  logic signed [rau_pkg::OW-1:0]    b_den,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic signed [rau_pkg::NUM_W-1:0] res_num,
	output logic [rau_pkg::DEN_W-1:0]        res_den,
	output logic                             undefined
);
	import rau_pkg::*;

	cmd_t  cmd;
	stat_t st;

	rau_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.st       (st),
		.cmd      (cmd)
	);

	rau_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.st        (st),
		.func      (func),
		.a_num     (a_num),
		.a_den     (a_den),
		.b_num     (b_num),
		.b_den     (b_den),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.res_num   (res_num),
		.res_den   (res_den),
		.undefined (undefined)
	);

endmodule

>>> design/rau_ctrl.sv
// Sequencing state machine of the rational arithmetic unit
module rau_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  rau_pkg::stat_t st,
	output rau_pkg::cmd_t  cmd
);
	import rau_pkg::*;

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_CHECK = 4'd1;
	localparam logic [3:0] S_MUL1  = 4'd2;
	localparam logic [3:0] S_MUL2  = 4'd3;
	localparam logic [3:0] S_GCD1  = 4'd4;
	localparam logic [3:0] S_DIVA  = 4'd5;
	localparam logic [3:0] S_DIVB  = 4'd6;
	localparam logic [3:0] S_ML1   = 4'd7;
	localparam logic [3:0] S_ML2   = 4'd8;
	localparam logic [3:0] S_ML3   = 4'd9;
	localparam logic [3:0] S_RED   = 4'd10;
	localparam logic [3:0] S_GCD2  = 4'd11;
	localparam logic [3:0] S_DIVN  = 4'd12;
	localparam logic [3:0] S_DIVD  = 4'd13;
	localparam logic [3:0] S_FIN   = 4'd14;

	logic [3:0] state_q;
	logic [3:0] state_d;

	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_CHECK;
				end
			end
			S_CHECK: begin
				if (st.undef) begin
					state_d = S_FIN;
				end else if (st.addsub) begin
					cmd.gcd_load = 1'b1;
					cmd.gcd_src  = GCD_DEN;
					state_d      = S_GCD1;
				end else begin
					state_d = S_MUL1;
				end
			end
			S_MUL1: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_NN;
				state_d     = S_MUL2;
			end
			S_MUL2: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_DD;
				state_d     = S_RED;
			end
			S_GCD1: begin
				cmd.gcd_step = 1'b1;
				if (st.gcd_eq) begin
					cmd.div_load = 1'b1;
					cmd.div_src  = DIV_AD;
					state_d      = S_DIVA;
				end
			end
			S_DIVA: begin
				cmd.div_step = 1'b1;
				if (st.div_last) begin
					cmd.div_load = 1'b1;
					cmd.div_src  = DIV_BD;
					state_d      = S_DIVB;
				end
			end
			S_DIVB: begin
				cmd.div_step = 1'b1;
				if (st.div_last) begin
					state_d = S_ML1;
				end
			end
			S_ML1: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_ADQB;
				state_d     = S_ML2;
			end
			S_ML2: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_ANQB;
				state_d     = S_ML3;
			end
			S_ML3: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_ACC;
				state_d     = S_RED;
			end
			S_RED: begin
				if (st.rn_zero) begin
					state_d = S_FIN;
				end else begin
					cmd.gcd_load = 1'b1;
					cmd.gcd_src  = GCD_RES;
					state_d      = S_GCD2;
				end
			end
			S_GCD2: begin
				cmd.gcd_step = 1'b1;
				if (st.gcd_eq) begin
					cmd.div_load = 1'b1;
					cmd.div_src  = DIV_RN;
					state_d      = S_DIVN;
				end
			end
			S_DIVN: begin
				cmd.div_step = 1'b1;
				if (st.div_last) begin
					cmd.div_load = 1'b1;
					cmd.div_src  = DIV_RD;
					state_d      = S_DIVD;
				end
			end
			S_DIVD: begin
				cmd.div_step = 1'b1;
				if (st.div_last) begin
					state_d = S_FIN;
				end
			end
			S_FIN: begin
				if (st.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

>>> design/rau_dp.sv
// Datapath of the rational arithmetic unit: operands, binary gcd, divider, multiplier, output
`include "rational_arithmetic_unit_assert.svh"
module rau_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  rau_pkg::cmd_t                       cmd,
	output rau_pkg::stat_t                      st,
	input  logic [1:0]                          func,
	input  logic signed [rau_pkg::OW-1:0]       a_num,
	input  logic signed [rau_pkg::OW-1:0]       a_den,
	input  logic signed [rau_pkg::OW-1:0]       b_num,
	input  logic signed [rau_pkg::OW-1:0]       b_den,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [rau_pkg::NUM_W-1:0]    res_num,
	output logic [rau_pkg::DEN_W-1:0]           res_den,
	output logic                                undefined
);
	import rau_pkg::*;

	logic signed [OW:0] an_x, ad_x, bn_x, bd_x;
	logic signed [OW:0] an_n, ad_n, bn_n, bd_n;
	logic signed [OW:0] rbn, rbd;
	logic signed [OW:0] an_q, ad_q, bn_q, bd_q;
	logic signed [OW:0] qa_q, qb_q;
	logic [1:0]         op_q;
	logic               undef_q;
	logic               undef_d;

	logic signed [MW:0] rn_q;
	logic [MW-1:0]      rd_q;
	logic [MW-1:0]      rn_mag;

	logic [MW-1:0] gx_q, gy_q, g_q;
	logic [KW-1:0] gk_q;
	logic          gcd_eq;

	logic [MW:0]   rem_q, r2, rem_n;
	logic [MW-1:0] dq_q, q_n;
	logic [CW-1:0] dcnt_q;
	logic [1:0]    dsrc_q;
	logic          ge;
	logic          div_last;

	logic signed [OW:0]     mul_a, mul_b;
	logic signed [2*OW+1:0] prod;

	logic                    out_valid_q;
	logic signed [NUM_W-1:0] res_num_q;
	logic [DEN_W-1:0]        res_den_q;
	logic                    undefined_q;

	always_comb begin
		an_x = {a_num[OW-1], a_num};
		ad_x = {a_den[OW-1], a_den};
		bn_x = {b_num[OW-1], b_num};
		bd_x = {b_den[OW-1], b_den};
		an_n = ad_x[OW] ? -an_x : an_x;
		ad_n = ad_x[OW] ? -ad_x : ad_x;
		bn_n = bd_x[OW] ? -bn_x : bn_x;
		bd_n = bd_x[OW] ? -bd_x : bd_x;
		rbn  = bn_n;
		rbd  = bd_n;
		if (func == OP_DIV) begin
			rbn = bn_n[OW] ? -bd_n : bd_n;
			rbd = bn_n[OW] ? -bn_n : bn_n;
		end
		undef_d = (ad_n == '0) || (bd_n == '0) || ((func == OP_DIV) && (bn_n == '0));
	end

	assign rn_mag = rn_q[MW] ? MW'(-rn_q) : MW'(rn_q);
	assign gcd_eq = (gx_q == gy_q);

	assign r2       = {rem_q[MW-1:0], dq_q[MW-1]};
	assign ge       = (r2 >= {1'b0, g_q});
	assign rem_n    = ge ? (r2 - {1'b0, g_q}) : r2;
	assign q_n      = {dq_q[MW-2:0], ge};
	assign div_last = (dcnt_q == CW'(MW - 1));

	always_comb begin
		mul_a = an_q;
		mul_b = bn_q;
		case (cmd.mul_sel)
			MUL_NN: begin
				mul_a = an_q;
				mul_b = bn_q;
			end
			MUL_DD: begin
				mul_a = ad_q;
				mul_b = bd_q;
			end
			MUL_ADQB: begin
				mul_a = ad_q;
				mul_b = qb_q;
			end
			MUL_ANQB: begin
				mul_a = an_q;
				mul_b = qb_q;
			end
			MUL_ACC: begin
				mul_a = bn_q;
				mul_b = qa_q;
			end
			default: begin
				mul_a = an_q;
				mul_b = bn_q;
			end
		endcase
	end

	assign prod = mul_a * mul_b;

	// operand capture
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			an_q    <= an_n;
			ad_q    <= ad_n;
			bn_q    <= rbn;
			bd_q    <= rbd;
			op_q    <= func;
			undef_q <= undef_d;
		end
	end

	// binary gcd, one step per cycle
	always_ff @(posedge clk) begin
		if (cmd.gcd_load) begin
			gk_q <= '0;
			if (cmd.gcd_src == GCD_DEN) begin
				gx_q <= MW'($unsigned(ad_q));
				gy_q <= MW'($unsigned(bd_q));
			end else begin
				gx_q <= rn_mag;
				gy_q <= rd_q;
			end
		end else if (cmd.gcd_step) begin
			if (gcd_eq) begin
				g_q <= gx_q << gk_q;
			end else if (!gx_q[0] && !gy_q[0]) begin
				gx_q <= gx_q >> 1;
				gy_q <= gy_q >> 1;
				gk_q <= gk_q + KW'(1);
			end else if (!gx_q[0]) begin
				gx_q <= gx_q >> 1;
			end else if (!gy_q[0]) begin
				gy_q <= gy_q >> 1;
			end else if (gx_q > gy_q) begin
				gx_q <= gx_q - gy_q;
			end else begin
				gy_q <= gy_q - gx_q;
			end
		end
	end

	// restoring divider by the gcd, one quotient bit per cycle
	always_ff @(posedge clk) begin
		if (cmd.div_load) begin
			rem_q  <= '0;
			dcnt_q <= '0;
			dsrc_q <= cmd.div_src;
			case (cmd.div_src)
				DIV_AD:  dq_q <= MW'($unsigned(ad_q));
				DIV_BD:  dq_q <= MW'($unsigned(bd_q));
				DIV_RN:  dq_q <= rn_mag;
				DIV_RD:  dq_q <= rd_q;
				default: dq_q <= rd_q;
			endcase
		end else if (cmd.div_step) begin
			rem_q  <= rem_n;
			dq_q   <= q_n;
			dcnt_q <= dcnt_q + CW'(1);
		end
	end

	// result registers: products and reduced quotients
	always_ff @(posedge clk) begin
		if (cmd.mul_en) begin
			case (cmd.mul_sel)
				MUL_NN, MUL_ANQB: rn_q <= (MW+1)'(prod);
				MUL_DD, MUL_ADQB: rd_q <= MW'(prod);
				MUL_ACC: begin
					if (op_q == OP_SUB) begin
						rn_q <= rn_q - (MW+1)'(prod);
					end else begin
						rn_q <= rn_q + (MW+1)'(prod);
					end
				end
				default: rn_q <= rn_q;
			endcase
		end else if (cmd.div_step && div_last) begin
			case (dsrc_q)
				DIV_AD:  qa_q <= (OW+1)'(q_n);
				DIV_BD:  qb_q <= (OW+1)'(q_n);
				DIV_RN:  rn_q <= rn_q[MW] ? -$signed({1'b0, q_n}) : $signed({1'b0, q_n});
				DIV_RD:  rd_q <= q_n;
				default: rd_q <= q_n;
			endcase
		end
	end

	// output word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			undefined_q <= undef_q;
			if (undef_q) begin
				res_num_q <= '0;
				res_den_q <= '0;
			end else if (rn_q == '0) begin
				res_num_q <= '0;
				res_den_q <= DEN_W'(1);
			end else begin
				res_num_q <= NUM_W'(rn_q);
				res_den_q <= DEN_W'(rd_q);
			end
		end
	end

	assign out_valid = out_valid_q;
	assign res_num   = res_num_q;
	assign res_den   = res_den_q;
	assign undefined = undefined_q;

	assign st.undef    = undef_q;
	assign st.addsub   = op_q inside {OP_ADD, OP_SUB};
	assign st.gcd_eq   = gcd_eq;
	assign st.div_last = div_last;
	assign st.rn_zero  = (rn_q == '0);
	assign st.out_free = !out_valid_q || !out_stall;

	`RAU_ASSERT_NOW(a_gcd_nonzero, cmd.gcd_step, (gx_q != '0) && (gy_q != '0), "gcd stepped on zero operand")
	`RAU_ASSERT_NOW(a_undef_zero, out_valid_q && undefined_q, (res_num_q == '0) && (res_den_q == '0), "undefined word not 0/0")
	`RAU_ASSERT_NOW(a_den_nonzero, out_valid_q && !undefined_q, res_den_q != '0, "defined word with zero denominator")

endmodule

>>> verif/rational_arithmetic_unit_checker.sv
// Checker for the rational arithmetic unit: predicts each reduced fraction and compares results
module rational_arithmetic_unit_checker (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	input  logic                             in_stall,
	input  logic [1:0]                       func,
	input  logic signed [rau_pkg::OW-1:0]    a_num,
	input  logic signed [rau_pkg::OW-1:0]    a_den,
	input  logic signed [rau_pkg::OW-1:0]    b_num,
	input  logic signed [rau_pkg::OW-1:0]    b_den,
	input  logic                             out_valid,
	input  logic                             out_stall,
	input  logic signed [rau_pkg::NUM_W-1:0] res_num,
	input  logic [rau_pkg::DEN_W-1:0]        res_den,
	input  logic                             undefined,
	output int                               errors,
	output int                               pending
);
	timeunit 1ns;
	timeprecision 1ps;
	import rau_pkg::*;

	typedef struct {
		logic signed [NUM_W-1:0] num;
		logic [DEN_W-1:0]        den;
		logic                    undef;
	} fraction_t;

	fraction_t fractions_due[$];

	function automatic longint gcd_of(longint x, longint y);
		longint t;
		while (y != 0) begin
			t = x % y;
			x = y;
			y = t;
		end
		return x;
	endfunction

	function automatic fraction_t reduce_fraction(logic [1:0] op, longint an, longint ad,
			longint bn, longint bd);
		fraction_t f;
		longint rn, rd, g, l, rbn, rbd;
		logic bad;
		bad = 1'b0;
		rn = 0;
		rd = 0;
		if (ad < 0) begin
			an = -an;
			ad = -ad;
		end
		if (bd < 0) begin
			bn = -bn;
			bd = -bd;
		end
		if (ad == 0 || bd == 0) begin
			bad = 1'b1;
		end else if (op inside {OP_ADD, OP_SUB}) begin
			g = gcd_of(ad, bd);
			l = (ad / g) * bd;
			rn = (op == OP_ADD) ? an * (l / ad) + bn * (l / bd) : an * (l / ad) - bn * (l / bd);
			rd = l;
		end else if (op == OP_MUL) begin
			rn = an * bn;
			rd = ad * bd;
		end else begin
			rbn = bd;
			rbd = bn;
			if (rbd < 0) begin
				rbn = -rbn;
				rbd = -rbd;
			end
			if (rbd == 0) begin
				bad = 1'b1;
			end else begin
				rn = an * rbn;
				rd = ad * rbd;
			end
		end
		if (bad) begin
			rn = 0;
			rd = 0;
		end else if (rn == 0) begin
			rd = 1;
		end else begin
			g = gcd_of(rn < 0 ? -rn : rn, rd);
			if (g > 1) begin
				rn = rn / g;
				rd = rd / g;
			end
		end
		f.num = rn[NUM_W-1:0];
		f.den = rd[DEN_W-1:0];
		f.undef = bad;
		return f;
	endfunction

	assign pending = fractions_due.size();

	initial errors = 0;

	always @(posedge clk) begin
		fraction_t e;
		if (arst_n) begin
			if (in_valid && !in_stall)
				fractions_due.push_back(reduce_fraction(func, a_num, a_den, b_num, b_den));
			if (out_valid && !out_stall) begin
				if (fractions_due.size() == 0) begin
					$error("result word with no expectation waiting");
					errors++;
				end else begin
					e = fractions_due.pop_front();
					if (res_num !== e.num) begin
						$error("res_num expected %0d actual %0d", e.num, res_num);
						errors++;
					end
					if (res_den !== e.den) begin
						$error("res_den expected %0d actual %0d", e.den, res_den);
						errors++;
					end
					if (undefined !== e.undef) begin
						$error("undefined expected %0b actual %0b", e.undef, undefined);
						errors++;
					end
				end
			end
		end
	end
endmodule

>>> verif/testbench.sv
// Testbench top for the rational arithmetic unit: stimulus, stall patterns and verdict
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import rau_pkg::*;

	logic                    clk;
	logic                    arst_n;
	logic                    in_valid;
	logic                    in_stall;
	logic [1:0]              func;
	logic signed [OW-1:0]    a_num, a_den, b_num, b_den;
	logic                    out_valid;
	logic                    out_stall;
	logic signed [NUM_W-1:0] res_num;
	logic [DEN_W-1:0]        res_den;
	logic                    undefined;
	int                      errors;
	int                      pending;
	int                      idle_cycles;
	int                      cycle;
	bit                      hold_req;

	rational_arithmetic_unit i_dut (.*);

	rational_arithmetic_unit_checker i_checker (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// receiver: stall pattern switches among four modes as the cycle count grows, long hold-off on request
	initial begin
		out_stall = 1'b0;
		cycle = 0;
		hold_req = 1'b0;
		forever begin
			@(posedge clk);
			cycle++;
			if (hold_req) begin
				hold_req = 1'b0;
				out_stall <= 1'b1;
				repeat (3000) @(posedge clk);
			end
			case ((cycle / 500) % 4)
				0: out_stall <= 1'b0;
				1: out_stall <= ($urandom_range(0, 99) < 30);
				2: out_stall <= ($urandom_range(0, 99) < 80);
				default: out_stall <= (cycle % 3 == 0);
			endcase
		end
	end

	initial begin
		idle_cycles = 0;
		forever begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= 10000) begin
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

	task automatic send_word(logic [1:0] op, logic signed [OW-1:0] an, logic signed [OW-1:0] ad,
			logic signed [OW-1:0] bn, logic signed [OW-1:0] bd, int gap);
		in_valid <= 1'b1;
		func <= op;
		a_num <= an;
		a_den <= ad;
		b_num <= bn;
		b_den <= bd;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	function automatic logic signed [OW-1:0] pick_part(bit is_den);
		int r;
		r = $urandom_range(0, 99);
		if (is_den && r < 3)
			return '0;
		if (r < 45)
			return OW'(int'($urandom_range(0, 40)) - 20);
		if (r < 55) begin
			case ($urandom_range(0, 4))
				0: return 16'sh8000;
				1: return 16'sh7fff;
				2: return 16'sh0001;
				3: return -16'sh0001;
				default: return 16'sh0000;
			endcase
		end
		return OW'($urandom());
	endfunction

	initial begin
		int burst;
		logic [1:0] op;
		logic signed [OW-1:0] bn;
		in_valid = 1'b0;
		func = OP_ADD;
		a_num = '0;
		a_den = 16'sd1;
		b_num = '0;
		b_den = 16'sd1;
		arst_n = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_word(OP_ADD, 16'sd1, 16'sd2, 16'sd1, 16'sd3, 0);
		send_word(OP_SUB, 16'sd1, 16'sd2, 16'sd1, 16'sd2, 0);
		send_word(OP_MUL, 16'sd3, -16'sd4, 16'sd2, 16'sd9, 0);
		send_word(OP_DIV, 16'sd3, 16'sd4, -16'sd2, 16'sd9, 0);
		send_word(OP_ADD, 16'sd1, 16'sd0, 16'sd1, 16'sd1, 0);
		send_word(OP_MUL, 16'sd1, 16'sd1, 16'sd1, 16'sd0, 0);
		send_word(OP_DIV, 16'sd5, 16'sd7, 16'sd0, 16'sd3, 0);
		send_word(OP_DIV, 16'sd0, 16'sd7, 16'sd4, 16'sd3, 0);
		send_word(OP_MUL, 16'sd0, 16'sd5, 16'sd9, 16'sd2, 0);
		send_word(OP_ADD, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 0);
		send_word(OP_SUB, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff, 0);
		send_word(OP_MUL, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff, 0);
		send_word(OP_MUL, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 0);
		send_word(OP_DIV, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff, 0);
		send_word(OP_DIV, 16'sh7fff, 16'sh8001, 16'sh8000, 16'sh0001, 0);
		send_word(OP_ADD, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7ffe, 0);
		send_word(OP_SUB, 16'sh7fff, 16'sh7ffe, -16'sh7fff, 16'sh7ffd, 0);
		send_word(OP_ADD, -16'sd1, -16'sd1, -16'sd1, -16'sd1, 0);
		send_word(OP_SUB, 16'sd0, -16'sd3, 16'sd0, 16'sd5, 0);
		send_word(OP_DIV, 16'sd6, -16'sd9, -16'sd4, -16'sd6, 3);

		for (int n = 0; n < 1900; n++) begin
			if (n == 400)
				hold_req = 1'b1;
			if (n == 900 || n == 1500) begin
				in_valid <= 1'b0;
				@(posedge clk);
				while (pending != 0) @(posedge clk);
			end
			if (burst <= 0)
				burst = $urandom_range(1, 12);
			burst--;
			op = 2'($urandom_range(0, 3));
			bn = pick_part(1'b0);
			if (op == OP_DIV && $urandom_range(0, 19) == 0)
				bn = '0;
			send_word(op, pick_part(1'b0), pick_part(1'b1), bn, pick_part(1'b1),
				burst == 0 ? $urandom_range(1, 200) : 0);
		end
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (300) @(posedge clk);
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end
endmodule

>>> filelist.f
+incdir+design
design/rau_pkg.sv
design/rau_ctrl.sv
design/rau_dp.sv
design/rational_arithmetic_unit.sv
verif/rational_arithmetic_unit_checker.sv
verif/testbench.sv
